// ===== rtl/udhcp_pkg.sv =====
// Shared constants and control types for the DHCP-over-IPv4/UDP header parser.
`timescale 1ns / 1ps
package udhcp_pkg;

   localparam int CHUNK_BYTES_DEFAULT = 8;
   localparam int MAX_CHUNKS          = 32;

   localparam logic [31:0] MAGIC_COOKIE = 32'h63825363;
   localparam logic [15:0] DHCP_FIXED   = 16'd236;
   localparam logic [15:0] OPTION_START = 16'd240;
   localparam logic [15:0] IP_HDR_MIN   = 16'd20;
   localparam logic [15:0] UDP_HDR      = 16'd8;
   localparam logic [15:0] UDP_LEN_MIN  = 16'd248;
   localparam logic [15:0] PORT_SERVER  = 16'd67;
   localparam logic [15:0] PORT_CLIENT  = 16'd68;
   localparam logic [7:0]  PROTO_UDP    = 8'd17;
   localparam logic [3:0]  IP_VERSION   = 4'd4;
   localparam logic [15:0] FRAG_MASK    = 16'h3fff;
   localparam logic [15:0] POS_MAX      = 16'hffff;

   localparam logic [7:0] OPT_PAD      = 8'd0;
   localparam logic [7:0] OPT_HOSTNAME = 8'd12;
   localparam logic [7:0] OPT_REQ_ADDR = 8'd50;
   localparam logic [7:0] OPT_END      = 8'd255;
   localparam logic [7:0] NAME_MAX     = 8'd255;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_BAD_IP    = 4'd1;
   localparam logic [3:0] ST_FRAGMENT  = 4'd2;
   localparam logic [3:0] ST_NOT_UDP   = 4'd3;
   localparam logic [3:0] ST_BAD_UDP   = 4'd4;
   localparam logic [3:0] ST_NOT_DHCP  = 4'd5;
   localparam logic [3:0] ST_BAD_COOKIE = 4'd6;
   localparam logic [3:0] ST_TRUNCATED = 4'd7;
   localparam logic [3:0] ST_ZERO_MAC  = 4'd8;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // a packet byte is taken this cycle
      logic start;    // evaluate the packet and read the first name row
      logic load;     // fill the output register from the row just read
      logic next;     // advance to the next chunk and read its row
      logic clear;    // drop the per-packet state
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_last; // the beat in the output register closes the packet
   } sts_type;

endpackage

// ===== rtl/udhcp_ifs.sv =====
// Valid/ready channel interfaces for packet bytes in and observation beats out.
`timescale 1ns / 1ps
interface udhcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_packet;

   modport source (output valid, output data_byte, output end_of_packet, input ready);
   modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface udhcp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [47:0] mac_address;
   logic [31:0] ip_address;
   logic        ip_present;
   logic [7:0]  name_length;
   logic [63:0] name_chunk;
   logic [4:0]  chunk_index;
   logic        last;

   modport source (output valid, output status, output mac_address, output ip_address,
                   output ip_present, output name_length, output name_chunk,
                   output chunk_index, output last, input ready);
   modport sink   (input valid, input status, input mac_address, input ip_address,
                   input ip_present, input name_length, input name_chunk,
                   input chunk_index, input last, output ready);
endinterface

// ===== rtl/ipv4_udp_dhcp_observation_parser.sv =====
// Top level of the DHCP-over-IPv4/UDP observation parser.
//
// Usage: an IPv4 packet enters on req_ch one byte per beat, starting at the
// first byte of the IP header, with end_of_packet set on its final byte. The
// block captures the IP, UDP and DHCP header fields as they pass and walks the
// DHCP options on the fly, keeping the last hostname option in a row-wide
// memory of CHUNK_BYTES bytes per row.
// Flow: packet bytes are taken one per cycle while req_ch is ready. After the
// final byte the block evaluates the packet and then emits on rsp_ch: a
// rejected packet gives one status beat, an accepted one gives one beat per
// hostname chunk (at least one, at most 32). For each beat a row of the
// hostname memory is read, then loaded into the output register and held
// there until taken. req_ch is not ready from the final byte until the last
// beat is taken.
// Reset: the synchronous reset clears all packet state and the controller;
// the hostname memory is not cleared, since bytes beyond the current name
// length are masked to zero on output.
// Stall: when the receiver holds rsp_ready low, the beat in the output
// register stays valid and unchanged, and no packet byte is taken.
`timescale 1ns / 1ps
module ipv4_udp_dhcp_observation_parser import udhcp_pkg::*; #(
   parameter int CHUNK_BYTES = CHUNK_BYTES_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   udhcp_req_if.sink   req_ch,
   udhcp_rsp_if.source rsp_ch
);

   cmd_type cmd;
   sts_type sts;

   // The controller owns the handshakes; the datapath owns every payload bit.
   udhcp_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_end_of_packet (req_ch.end_of_packet),
      .req_ready         (req_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .cmd               (cmd),
      .sts               (sts)
   );

   udhcp_dp #(
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .data_byte   (req_ch.data_byte),
      .status      (rsp_ch.status),
      .mac_address (rsp_ch.mac_address),
      .ip_address  (rsp_ch.ip_address),
      .ip_present  (rsp_ch.ip_present),
      .name_length (rsp_ch.name_length),
      .name_chunk  (rsp_ch.name_chunk),
      .chunk_index (rsp_ch.chunk_index),
      .last        (rsp_ch.last)
   );

endmodule

// ===== rtl/udhcp_dp.sv =====
// Datapath: header capture, option walk, hostname memory and output register.
`timescale 1ns / 1ps
module udhcp_dp import udhcp_pkg::*; #(
   parameter int CHUNK_BYTES = CHUNK_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [7:0]  data_byte,
   output logic [3:0]  status,
   output logic [47:0] mac_address,
   output logic [31:0] ip_address,
   output logic        ip_present,
   output logic [7:0]  name_length,
   output logic [63:0] name_chunk,
   output logic [4:0]  chunk_index,
   output logic        last
);

   localparam int NAME_ROWS = (255 + CHUNK_BYTES - 1) / CHUNK_BYTES;
   localparam int ROW_W     = $clog2(NAME_ROWS);
   localparam int LANE_W    = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
   localparam int ROW_BITS  = 8 * CHUNK_BYTES;
   localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(CHUNK_BYTES - 1);
   localparam logic [8:0]        BASE_STEP = 9'(CHUNK_BYTES);

   localparam logic [1:0] PH_CODE  = 2'd0;
   localparam logic [1:0] PH_LEN   = 2'd1;
   localparam logic [1:0] PH_VALUE = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   // Per-packet capture state.
   logic [15:0] pos_ff, pos_in;
   logic [5:0]  hl_ff, hl_in;
   logic [15:0] tot_ff, tot_in, frag_ff, frag_in;
   logic [7:0]  proto_ff, proto_in;
   logic [15:0] sport_ff, sport_in, dport_ff, dport_in, ulen_ff, ulen_in;
   logic [31:0] cookie_ff, cookie_in, yaddr_ff, yaddr_in, caddr_ff, caddr_in;
   logic [47:0] mac_ff, mac_in;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  ocode_ff, ocode_in, oleft_ff, oleft_in;
   logic [31:0] raddr_ff, raddr_in;
   logic        rvalid_ff, rvalid_in, len4_ff, len4_in, fail_ff, fail_in;
   logic [7:0]  ncount_ff, ncount_in;
   logic [ROW_W-1:0]  nrow_ff, nrow_in;
   logic [LANE_W-1:0] nlane_ff, nlane_in;

   // Emission state.
   logic [4:0] k_ff, k_in;
   logic [8:0] base_ff, base_in;
   logic [3:0] stat_ff, stat_in;

   // Output register.
   logic [3:0]  o_status_ff;
   logic [47:0] o_mac_ff;
   logic [31:0] o_ip_ff;
   logic        o_present_ff;
   logic [7:0]  o_len_ff;
   logic [63:0] o_chunk_ff;
   logic [4:0]  o_index_ff;
   logic        o_last_ff;

   // Hostname memory, one row per chunk.
   logic [ROW_BITS-1:0] name_mem [NAME_ROWS];
   logic [ROW_BITS-1:0] rd_q;
   logic [ROW_W-1:0]    rd_row;
   logic                rd_en, wr_en;

   logic [15:0] hl16, p_rel, d;
   logic        in_udp_hdr, in_dhcp;
   logic [3:0]  pkt_status;
   logic [16:0] udp_end;
   logic        port_s_ok, port_d_ok;
   logic [ROW_BITS-1:0] masked_row;
   logic        chunk_last;

   assign hl16       = {10'd0, hl_ff};
   assign p_rel      = pos_ff - hl16;
   assign in_udp_hdr = (pos_ff >= hl16) && (p_rel < UDP_HDR);
   assign in_dhcp    = (pos_ff >= hl16) && (p_rel >= UDP_HDR) && (ulen_ff >= UDP_HDR)
                       && ((p_rel - UDP_HDR) < (ulen_ff - UDP_HDR));
   assign d          = p_rel - UDP_HDR;

   always_comb begin
      pos_in = pos_ff;   hl_in = hl_ff;   tot_in = tot_ff;   frag_in = frag_ff;
      proto_in = proto_ff;   sport_in = sport_ff;   dport_in = dport_ff;
      ulen_in = ulen_ff;   cookie_in = cookie_ff;   yaddr_in = yaddr_ff;
      caddr_in = caddr_ff;   mac_in = mac_ff;   phase_in = phase_ff;
      ocode_in = ocode_ff;   oleft_in = oleft_ff;   raddr_in = raddr_ff;
      rvalid_in = rvalid_ff;   len4_in = len4_ff;   fail_in = fail_ff;
      ncount_in = ncount_ff;   nrow_in = nrow_ff;   nlane_in = nlane_ff;
      wr_en = 1'b0;
      if (cmd.clear) begin
         pos_in = '0;   hl_in = '0;   tot_in = '0;   frag_in = '0;   proto_in = '0;
         sport_in = '0;   dport_in = '0;   ulen_in = '0;   cookie_in = '0;
         yaddr_in = '0;   caddr_in = '0;   mac_in = '0;   phase_in = PH_CODE;
         ocode_in = '0;   oleft_in = '0;   raddr_in = '0;   rvalid_in = 1'b0;
         len4_in = 1'b0;   fail_in = 1'b0;   ncount_in = '0;   nrow_in = '0;
         nlane_in = '0;
      end else if (cmd.accept) begin
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 16'd1;
         end
         if (pos_ff == 16'd0) begin
            hl_in   = {data_byte[3:0], 2'b00};
            len4_in = 1'b0;
            if ((data_byte[7:4] != IP_VERSION) || ({10'd0, data_byte[3:0], 2'b00} < IP_HDR_MIN))
            begin
               fail_in = 1'b1;
            end
         end else if (!fail_ff) begin
            if (pos_ff inside {16'd2, 16'd3}) begin
               tot_in = {tot_ff[7:0], data_byte};
            end else if (pos_ff inside {16'd6, 16'd7}) begin
               frag_in = {frag_ff[7:0], data_byte};
            end else if (pos_ff == 16'd9) begin
               proto_in = data_byte;
            end
            if (in_udp_hdr) begin
               if (p_rel < 16'd2) begin
                  sport_in = {sport_ff[7:0], data_byte};
               end else if (p_rel < 16'd4) begin
                  dport_in = {dport_ff[7:0], data_byte};
               end else if (p_rel < 16'd6) begin
                  ulen_in = {ulen_ff[7:0], data_byte};
               end
            end else if (in_dhcp) begin
               if (d inside {[16'd12:16'd15]}) begin
                  caddr_in = {caddr_ff[23:0], data_byte};
               end else if (d inside {[16'd16:16'd19]}) begin
                  yaddr_in = {yaddr_ff[23:0], data_byte};
               end else if (d inside {[16'd28:16'd33]}) begin
                  mac_in = {mac_ff[39:0], data_byte};
               end else if (d inside {[DHCP_FIXED:DHCP_FIXED + 16'd3]}) begin
                  cookie_in = {cookie_ff[23:0], data_byte};
               end else if (d >= OPTION_START) begin
                  case (phase_ff)
                     PH_CODE: begin
                        if (data_byte == OPT_END) begin
                           phase_in = PH_DONE;
                        end else if (data_byte != OPT_PAD) begin
                           ocode_in = data_byte;
                           phase_in = PH_LEN;
                        end
                     end
                     PH_LEN: begin
                        oleft_in = data_byte;
                        len4_in  = (data_byte == 8'd4);
                        if (ocode_ff == OPT_HOSTNAME) begin
                           ncount_in = '0;
                           nrow_in   = '0;
                           nlane_in  = '0;
                        end
                        if ((ocode_ff == OPT_REQ_ADDR) && (data_byte == 8'd4) && !rvalid_ff)
                        begin
                           raddr_in = '0;
                        end
                        phase_in = (data_byte == 8'd0) ? PH_CODE : PH_VALUE;
                     end
                     PH_VALUE: begin
                        if ((ocode_ff == OPT_HOSTNAME) && (ncount_ff != NAME_MAX)) begin
                           wr_en     = 1'b1;
                           ncount_in = ncount_ff + 8'd1;
                           if (nlane_ff == LANE_LAST) begin
                              nlane_in = '0;
                              nrow_in  = nrow_ff + ROW_W'(1);
                           end else begin
                              nlane_in = nlane_ff + LANE_W'(1);
                           end
                        end
                        oleft_in = oleft_ff - 8'd1;
                        if ((ocode_ff == OPT_REQ_ADDR) && !rvalid_ff) begin
                           raddr_in = {raddr_ff[23:0], data_byte};
                        end
                        if (oleft_ff == 8'd1) begin
                           phase_in = PH_CODE;
                           if ((ocode_ff == OPT_REQ_ADDR) && len4_ff && !rvalid_ff) begin
                              rvalid_in = 1'b1;
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
      end
   end

   // Packet verdict, in the order the checks are defined.
   assign udp_end   = {1'b0, hl16} + {1'b0, ulen_ff};
   assign port_s_ok = (sport_ff == PORT_SERVER) || (sport_ff == PORT_CLIENT);
   assign port_d_ok = (dport_ff == PORT_SERVER) || (dport_ff == PORT_CLIENT);

   always_comb begin
      if ((pos_ff < IP_HDR_MIN) || fail_ff || (pos_ff < hl16) || (tot_ff < hl16)
          || (pos_ff < tot_ff)) begin
         pkt_status = ST_BAD_IP;
      end else if ((frag_ff & FRAG_MASK) != 16'd0) begin
         pkt_status = ST_FRAGMENT;
      end else if (proto_ff != PROTO_UDP) begin
         pkt_status = ST_NOT_UDP;
      end else if (((tot_ff - hl16) < UDP_HDR) || (ulen_ff < UDP_HDR)
                   || (udp_end > {1'b0, tot_ff})) begin
         pkt_status = ST_BAD_UDP;
      end else if (!port_s_ok || !port_d_ok) begin
         pkt_status = ST_NOT_DHCP;
      end else if ((ulen_ff < UDP_LEN_MIN) || (cookie_ff != MAGIC_COOKIE)) begin
         pkt_status = ST_BAD_COOKIE;
      end else if ((phase_ff == PH_LEN) || (phase_ff == PH_VALUE)) begin
         pkt_status = ST_TRUNCATED;
      end else if (mac_ff == 48'd0) begin
         pkt_status = ST_ZERO_MAC;
      end else begin
         pkt_status = ST_OK;
      end
   end

   // Emission counters.
   always_comb begin
      k_in    = k_ff;
      base_in = base_ff;
      stat_in = stat_ff;
      if (cmd.start) begin
         k_in    = '0;
         base_in = '0;
         stat_in = pkt_status;
      end else if (cmd.next) begin
         k_in    = k_ff + 5'd1;
         base_in = base_ff + BASE_STEP;
      end
   end

   assign rd_en  = cmd.start || cmd.next;
   assign rd_row = cmd.start ? '0 : ROW_W'(k_ff + 5'd1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         name_mem[nrow_ff][{nlane_ff, 3'b000} +: 8] <= data_byte;
      end
      if (rd_en) begin
         rd_q <= name_mem[rd_row];
      end
   end

   // Bytes past the hostname length read as zero.
   always_comb begin
      for (int j = 0; j < CHUNK_BYTES; j++) begin
         masked_row[8*j +: 8] = ((base_ff + 9'(j)) < {1'b0, ncount_ff}) ? rd_q[8*j +: 8]
                                                                         : 8'd0;
      end
   end

   assign chunk_last = ((base_ff + BASE_STEP) >= {1'b0, ncount_ff})
                       || (k_ff == 5'(MAX_CHUNKS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;   hl_ff <= '0;   tot_ff <= '0;   frag_ff <= '0;   proto_ff <= '0;
         sport_ff <= '0;   dport_ff <= '0;   ulen_ff <= '0;   cookie_ff <= '0;
         yaddr_ff <= '0;   caddr_ff <= '0;   mac_ff <= '0;   phase_ff <= PH_CODE;
         ocode_ff <= '0;   oleft_ff <= '0;   raddr_ff <= '0;   rvalid_ff <= 1'b0;
         len4_ff <= 1'b0;   fail_ff <= 1'b0;   ncount_ff <= '0;   nrow_ff <= '0;
         nlane_ff <= '0;   k_ff <= '0;   base_ff <= '0;   stat_ff <= ST_OK;
         o_last_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;   hl_ff <= hl_in;   tot_ff <= tot_in;   frag_ff <= frag_in;
         proto_ff <= proto_in;   sport_ff <= sport_in;   dport_ff <= dport_in;
         ulen_ff <= ulen_in;   cookie_ff <= cookie_in;   yaddr_ff <= yaddr_in;
         caddr_ff <= caddr_in;   mac_ff <= mac_in;   phase_ff <= phase_in;
         ocode_ff <= ocode_in;   oleft_ff <= oleft_in;   raddr_ff <= raddr_in;
         rvalid_ff <= rvalid_in;   len4_ff <= len4_in;   fail_ff <= fail_in;
         ncount_ff <= ncount_in;   nrow_ff <= nrow_in;   nlane_ff <= nlane_in;
         k_ff <= k_in;   base_ff <= base_in;   stat_ff <= stat_in;
         if (cmd.load) begin
            o_last_ff <= (stat_ff != ST_OK) || chunk_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         o_status_ff <= stat_ff;
         if (stat_ff != ST_OK) begin
            o_mac_ff     <= '0;
            o_ip_ff      <= '0;
            o_present_ff <= 1'b0;
            o_len_ff     <= '0;
            o_chunk_ff   <= '0;
            o_index_ff   <= '0;
         end else begin
            o_mac_ff <= mac_ff;
            if (yaddr_ff != 32'd0) begin
               o_ip_ff <= yaddr_ff;
            end else if (caddr_ff != 32'd0) begin
               o_ip_ff <= caddr_ff;
            end else if (rvalid_ff) begin
               o_ip_ff <= raddr_ff;
            end else begin
               o_ip_ff <= '0;
            end
            o_present_ff <= (yaddr_ff != 32'd0) || (caddr_ff != 32'd0) || rvalid_ff;
            o_len_ff     <= ncount_ff;
            o_chunk_ff   <= 64'(masked_row);
            o_index_ff   <= k_ff;
         end
      end
   end

   assign sts.out_last = o_last_ff;
   assign status       = o_status_ff;
   assign mac_address  = o_mac_ff;
   assign ip_address   = o_ip_ff;
   assign ip_present   = o_present_ff;
   assign name_length  = o_len_ff;
   assign name_chunk   = o_chunk_ff;
   assign chunk_index  = o_index_ff;
   assign last         = o_last_ff;

endmodule

// ===== rtl/udhcp_ctrl.sv =====
// Controller: sequences byte intake, packet evaluation and result emission.
`timescale 1ns / 1ps
module udhcp_ctrl import udhcp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_end_of_packet,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam logic [1:0] S_RUN  = 2'd0;
   localparam logic [1:0] S_EVAL = 2'd1;
   localparam logic [1:0] S_LOAD = 2'd2;
   localparam logic [1:0] S_SEND = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       take;

   assign req_ready = (state_ff == S_RUN);
   assign rsp_valid = (state_ff == S_SEND);
   assign take      = req_valid && req_ready;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.accept = take;
      case (state_ff)
         S_RUN: begin
            if (take && req_end_of_packet) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.start = 1'b1;
            state_in  = S_LOAD;
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_SEND;
         end
         S_SEND: begin
            if (rsp_ready) begin
               if (sts.out_last) begin
                  cmd.clear = 1'b1;
                  state_in  = S_RUN;
               end else begin
                  cmd.next = 1'b1;
                  state_in = S_LOAD;
               end
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
